@@ design/distance_constraint_solver_macros.svh @@
// Assertion macros shared by the distance constraint solver checker.
// No dependencies; included by the checker file only.
`ifndef DISTANCE_CONSTRAINT_SOLVER_MACROS_SVH
`define DISTANCE_CONSTRAINT_SOLVER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define DCS_AST_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Implication checked at every clock edge outside reset
`define DCS_AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ design/dcs_pkg.sv @@
// Types, constants and helpers for the distance constraint solver.
// No dependencies; used by the top level and its checker.
package dcs_pkg;

	localparam int STIFF_FRAC_BITS = 16;
	localparam logic [16:0] STIFF_RESET = 17'd32768;
	localparam int SQRT_STEPS = 34;
	localparam int DIV_STEPS = 31;
	// s1, s2, sqrt input plus its steps, divide set-up plus its steps, five tail stages
	localparam int LATENCY = 2 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 5;
	localparam logic signed [30:0] FAC_LIM = 31'sd536870912;

	typedef struct packed {
		logic signed [31:0] pos_a_x;
		logic signed [31:0] pos_a_y;
		logic signed [31:0] pos_a_z;
		logic signed [31:0] pos_b_x;
		logic signed [31:0] pos_b_y;
		logic signed [31:0] pos_b_z;
		logic [30:0] rest_length;
		logic a_free;
		logic b_free;
	} req_t;

	typedef struct packed {
		logic signed [31:0] new_a_x;
		logic signed [31:0] new_a_y;
		logic signed [31:0] new_a_z;
		logic signed [31:0] new_b_x;
		logic signed [31:0] new_b_y;
		logic signed [31:0] new_b_z;
		logic degenerate;
	} res_t;

	// Item plus its delta, carried down the pipeline
	typedef struct packed {
		req_t item;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
	} carry_t;

	// Saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

endpackage

@@ design/distance_constraint_solver.sv @@
// Distance constraint projection, fully pipelined top level.
// Depends on dcs_pkg for types, constants and saturation helpers.
//
//  channel   ports                          handshake
//  request   req (req_t)                    start, busy (always low)
//  result    res (res_t)                    done, one cycle
//  config    stiffness_wdata                stiffness_we
//
// One constraint is taken every cycle; the pipeline holds the 34 square-root
// steps and the 31 divide steps, one bit per stage. Reset clears the stage
// valid bits and restores stiffness. The receiver cannot stall, so the
// pipeline never holds.
module distance_constraint_solver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dcs_pkg::req_t     req,
	output logic              done,
	output dcs_pkg::res_t     res,
	input  logic              stiffness_we,
	input  logic [16:0]       stiffness_wdata
);

	localparam int NSQ = dcs_pkg::SQRT_STEPS;
	localparam int NDV = dcs_pkg::DIV_STEPS;

	logic [16:0] stiffness_q;

	// Stage 1: delta
	logic             v_s1;
	dcs_pkg::carry_t  car_s1;
	// Stage 2: squares
	logic             v_s2;
	dcs_pkg::carry_t  car_s2;
	logic [65:0]      sqx_s2, sqy_s2, sqz_s2;
	// Square root stages
	logic             sq_v   [0:NSQ];
	dcs_pkg::carry_t  sq_car [0:NSQ];
	logic [67:0]      sq_rem [0:NSQ];
	logic [33:0]      sq_root[0:NSQ];
	// Divide stages
	logic             dv_v   [0:NDV];
	dcs_pkg::carry_t  dv_car [0:NDV];
	logic [65:0]      dv_rem [0:NDV];
	logic [30:0]      dv_quo [0:NDV];
	logic [33:0]      dv_len [0:NDV];
	logic             dv_neg [0:NDV];
	logic             dv_ovf [0:NDV];
	logic             dv_deg [0:NDV];
	// Tail stages
	logic                   v_s3, v_s4, v_s5, v_s6;
	dcs_pkg::carry_t        car_s3, car_s4, car_s5, car_s6;
	logic                   deg_s3, deg_s4, deg_s5, deg_s6;
	logic signed [30:0]     ef_s3;
	logic signed [48:0]     fp_s4;
	logic signed [30:0]     fac_s5;
	logic signed [63:0]     cx_s6, cy_s6, cz_s6;
	logic                   done_q;
	dcs_pkg::res_t          res_q;

	assign busy = 1'b0;
	assign done = done_q;
	assign res  = res_q;

	// Hold stiffness between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= dcs_pkg::STIFF_RESET;
		end else if (stiffness_we) begin
			stiffness_q <= stiffness_wdata;
		end
	end

	// Advance the valid bits of the head and tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= dv_v[NDV];
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= v_s6;
		end
	end

	// Form the delta B minus A on 33 bits
	always_ff @(posedge clk) begin
		car_s1.item <= req;
		car_s1.dx   <= 33'(req.pos_b_x) - 33'(req.pos_a_x);
		car_s1.dy   <= 33'(req.pos_b_y) - 33'(req.pos_a_y);
		car_s1.dz   <= 33'(req.pos_b_z) - 33'(req.pos_a_z);
	end

	// Square each delta magnitude
	always_ff @(posedge clk) begin
		car_s2 <= car_s1;
		sqx_s2 <= dcs_pkg::mag33(car_s1.dx) * dcs_pkg::mag33(car_s1.dx);
		sqy_s2 <= dcs_pkg::mag33(car_s1.dy) * dcs_pkg::mag33(car_s1.dy);
		sqz_s2 <= dcs_pkg::mag33(car_s1.dz) * dcs_pkg::mag33(car_s1.dz);
	end

	// Sum of squares enters the square root chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_car[0]  <= car_s2;
		sq_rem[0]  <= 68'(sqx_s2) + 68'(sqy_s2) + 68'(sqz_s2);
		sq_root[0] <= '0;
	end

	// Restoring square root, one result bit per stage, top bit first
	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		localparam int K = NSQ - 1 - i;
		logic [67:0] trial;
		logic        take;

		assign trial = (68'(sq_root[i]) << (K + 1)) | (68'd1 << (2 * K));
		assign take  = (sq_rem[i] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_car[i+1]  <= sq_car[i];
			sq_rem[i+1]  <= take ? (sq_rem[i] - trial) : sq_rem[i];
			sq_root[i+1] <= take ? (sq_root[i] | (34'd1 << K)) : sq_root[i];
		end
	end

	// Set up the error divide: magnitude of length minus rest, overflow and degenerate tests
	logic signed [35:0] num_diff;
	logic [34:0]        num_mag;

	assign num_diff = 36'(sq_root[NSQ]) - 36'(sq_car[NSQ].item.rest_length);
	assign num_mag  = num_diff[35] ? 35'(-num_diff) : 35'(num_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= sq_v[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		dv_car[0] <= sq_car[NSQ];
		dv_rem[0] <= 66'(num_mag) << 16;
		dv_quo[0] <= '0;
		dv_len[0] <= sq_root[NSQ];
		dv_neg[0] <= num_diff[35];
		dv_ovf[0] <= (50'(num_mag) >= (50'(sq_root[NSQ]) << 15));
		dv_deg[0] <= (sq_root[NSQ] == '0);
	end

	// Restoring divide, one quotient bit per stage, top bit first
	for (genvar i = 0; i < NDV; i++) begin : g_div
		localparam int J = NDV - 1 - i;
		logic [65:0] dsr;
		logic        take;

		assign dsr  = 66'(dv_len[i]) << J;
		assign take = (dv_rem[i] >= dsr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i+1] <= 1'b0;
			end else begin
				dv_v[i+1] <= dv_v[i];
			end
		end

		always_ff @(posedge clk) begin
			dv_car[i+1] <= dv_car[i];
			dv_rem[i+1] <= take ? (dv_rem[i] - dsr) : dv_rem[i];
			dv_quo[i+1] <= take ? (dv_quo[i] | (31'd1 << J)) : dv_quo[i];
			dv_len[i+1] <= dv_len[i];
			dv_neg[i+1] <= dv_neg[i];
			dv_ovf[i+1] <= dv_ovf[i];
			dv_deg[i+1] <= dv_deg[i];
		end
	end

	// Sign the error factor and clamp its negative side
	always_ff @(posedge clk) begin
		car_s3 <= dv_car[NDV];
		deg_s3 <= dv_deg[NDV];
		if (!dv_neg[NDV]) begin
			ef_s3 <= dv_quo[NDV];
		end else if (dv_ovf[NDV] || (dv_quo[NDV] > 31'(dcs_pkg::FAC_LIM))) begin
			ef_s3 <= -dcs_pkg::FAC_LIM;
		end else begin
			ef_s3 <= -$signed(dv_quo[NDV]);
		end
	end

	// Scale by stiffness
	always_ff @(posedge clk) begin
		car_s4 <= car_s3;
		deg_s4 <= deg_s3;
		fp_s4  <= 49'(ef_s3) * 49'($signed({1'b0, stiffness_q}));
	end

	// Drop the stiffness fraction and clamp the factor
	logic signed [48:0] fp_shr;

	assign fp_shr = fp_s4 >>> dcs_pkg::STIFF_FRAC_BITS;

	always_ff @(posedge clk) begin
		car_s5 <= car_s4;
		deg_s5 <= deg_s4;
		if (fp_shr > 49'(dcs_pkg::FAC_LIM)) begin
			fac_s5 <= dcs_pkg::FAC_LIM;
		end else if (fp_shr < -49'(dcs_pkg::FAC_LIM)) begin
			fac_s5 <= -dcs_pkg::FAC_LIM;
		end else begin
			fac_s5 <= fp_shr[30:0];
		end
	end

	// Correction step per axis
	always_ff @(posedge clk) begin
		car_s6 <= car_s5;
		deg_s6 <= deg_s5;
		cx_s6  <= 64'(fac_s5) * 64'(car_s5.dx);
		cy_s6  <= 64'(fac_s5) * 64'(car_s5.dy);
		cz_s6  <= 64'(fac_s5) * 64'(car_s5.dz);
	end

	// Apply the step to free particles unless degenerate, saturate, register the result
	logic signed [49:0] stx, sty, stz;
	logic               mov_a, mov_b;

	assign stx   = 50'(cx_s6 >>> 16);
	assign sty   = 50'(cy_s6 >>> 16);
	assign stz   = 50'(cz_s6 >>> 16);
	assign mov_a = car_s6.item.a_free && !deg_s6;
	assign mov_b = car_s6.item.b_free && !deg_s6;

	always_ff @(posedge clk) begin
		res_q.new_a_x <= mov_a ? dcs_pkg::sat32(50'(car_s6.item.pos_a_x) + stx)
			: car_s6.item.pos_a_x;
		res_q.new_a_y <= mov_a ? dcs_pkg::sat32(50'(car_s6.item.pos_a_y) + sty)
			: car_s6.item.pos_a_y;
		res_q.new_a_z <= mov_a ? dcs_pkg::sat32(50'(car_s6.item.pos_a_z) + stz)
			: car_s6.item.pos_a_z;
		res_q.new_b_x <= mov_b ? dcs_pkg::sat32(50'(car_s6.item.pos_b_x) - stx)
			: car_s6.item.pos_b_x;
		res_q.new_b_y <= mov_b ? dcs_pkg::sat32(50'(car_s6.item.pos_b_y) - sty)
			: car_s6.item.pos_b_y;
		res_q.new_b_z <= mov_b ? dcs_pkg::sat32(50'(car_s6.item.pos_b_z) - stz)
			: car_s6.item.pos_b_z;
		res_q.degenerate <= deg_s6;
	end

endmodule

@@ design/dcs_checker.sv @@
// Port-level checker for the distance constraint solver, with its bind.
// Depends on dcs_pkg and distance_constraint_solver_macros.svh.
`include "distance_constraint_solver_macros.svh"

module dcs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input dcs_pkg::req_t req,
	input logic          done,
	input dcs_pkg::res_t res
);

	localparam int LAT = dcs_pkg::LATENCY;

	// Never refuse a transfer
	`DCS_AST_ALWAYS(a_never_busy, clk, arst_n, !busy)
	// Every result comes from an earlier transfer
	`DCS_AST_IMPL(a_done_follows_start, clk, arst_n, done, $past(start, LAT))
	// Coincident particles pass through unchanged, checked on A's x and B's z
	`DCS_AST_IMPL(a_degen_pass, clk, arst_n, done && res.degenerate, (res.new_a_x == $past(req.pos_a_x, LAT)) && (res.new_b_z == $past(req.pos_b_z, LAT)))
	// A pinned particle A keeps its position
	`DCS_AST_IMPL(a_pinned_a, clk, arst_n, done && !$past(req.a_free, LAT), (res.new_a_x == $past(req.pos_a_x, LAT)) && (res.new_a_y == $past(req.pos_a_y, LAT)) && (res.new_a_z == $past(req.pos_a_z, LAT)))

endmodule

bind distance_constraint_solver dcs_checker u_dcs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.res    (res)
);
